// ===== src/u8s8dp_pkg.sv =====
// ----------------------------------------------------------------------------
// u8s8dp_pkg
// Types, widths and helper functions shared by the u8 x s8 dot-product
// accumulator and its group multiply-add unit.
// ----------------------------------------------------------------------------
package u8s8dp_pkg;

  localparam int GROUP_SIZE = 4;
  localparam int NUM_PAIRS  = (GROUP_SIZE + 1) / 2;

  localparam int SRC_W  = 8;
  localparam int WT_W   = 8;
  localparam int PROD_W = SRC_W + WT_W + 1;
  localparam int PAIR_W = PROD_W + 1;
  localparam int GRP_W  = PAIR_W + $clog2(NUM_PAIRS);
  localparam int ACC_W  = 32;
  localparam int SAT_W  = 16;

  typedef logic        [SRC_W-1:0]  src_t;
  typedef logic signed [WT_W-1:0]   wt_t;
  typedef logic signed [PROD_W-1:0] prod_t;
  typedef logic signed [PAIR_W-1:0] pair_t;
  typedef logic signed [GRP_W-1:0]  grp_sum_t;
  typedef logic        [ACC_W-1:0]  acc_t;

  localparam pair_t SAT_MAX = pair_t'((1 << (SAT_W - 1)) - 1);
  localparam pair_t SAT_MIN = -pair_t'(1 << (SAT_W - 1));

  function automatic pair_t sat_pair(input pair_t value);
    pair_t result;
    result = value;
    if (value > SAT_MAX) begin
      result = SAT_MAX;
    end else if (value < SAT_MIN) begin
      result = SAT_MIN;
    end
    return result;
  endfunction

endpackage

// ===== src/u8s8dp_group.sv =====
// ----------------------------------------------------------------------------
// u8s8dp_group
// Multiplies one group of unsigned source bytes by signed weights, adds the
// products in adjacent pairs, optionally clamps each pair to signed 16 bits,
// and returns the sum of the pairs.
// ----------------------------------------------------------------------------
module u8s8dp_group
  import u8s8dp_pkg::*;
(
  input  src_t     src [GROUP_SIZE],
  input  wt_t      wt  [GROUP_SIZE],
  input  logic     saturate,
  output grp_sum_t grp_sum
);

  prod_t prod [GROUP_SIZE];
  pair_t pair [NUM_PAIRS];

  always_comb begin
    for (int i = 0; i < GROUP_SIZE; i++) begin
      prod[i] = prod_t'($signed({1'b0, src[i]})) * prod_t'(wt[i]);
    end
  end

  always_comb begin
    pair_t raw;
    for (int p = 0; p < NUM_PAIRS; p++) begin
      raw = pair_t'(prod[2*p]);
      if (2*p + 1 < GROUP_SIZE) begin
        raw = raw + pair_t'(prod[2*p + 1]);
      end
      pair[p] = saturate ? sat_pair(raw) : raw;
    end
  end

  always_comb begin
    grp_sum = '0;
    for (int p = 0; p < NUM_PAIRS; p++) begin
      grp_sum = grp_sum + grp_sum_t'(pair[p]);
    end
  end

endmodule

// ===== src/u8_s8_dot_product_accumulator.sv =====
// ----------------------------------------------------------------------------
// u8_s8_dot_product_accumulator
// Accepts one group of four byte pairs per cycle while in_stall is low and emits the 32-bit
// wrapping dot product on the group marked last.
// Data path: inputs are registered in stage 1, the group sum in stage 2, then the sum in the output register.
// Throughput: one group per cycle through the two-stage multiply-add pipeline, unless a held result stalls it.
// Reset: synchronous active-low rst_n clears valids, accumulator and mode.
// ----------------------------------------------------------------------------
module u8_s8_dot_product_accumulator
  import u8s8dp_pkg::*;
(
  input  logic               clk,
  input  logic               rst_n,

  input  logic               cfg_valid,
  output logic               cfg_ready,
  input  logic               cfg_saturate_pairs,

  input  logic               in_valid,
  output logic               in_stall,
  input  logic        [7:0]  in_src0,
  input  logic        [7:0]  in_src1,
  input  logic        [7:0]  in_src2,
  input  logic        [7:0]  in_src3,
  input  logic signed [7:0]  in_wt0,
  input  logic signed [7:0]  in_wt1,
  input  logic signed [7:0]  in_wt2,
  input  logic signed [7:0]  in_wt3,
  input  logic               in_last,

  output logic               out_valid,
  input  logic               out_stall,
  output logic signed [31:0] out_dot_sum
);

  logic     sat_r;
  logic     adv;

  logic     s1_valid_r;
  logic     s1_last_r;
  src_t     s1_src_r [GROUP_SIZE];
  wt_t      s1_wt_r  [GROUP_SIZE];

  grp_sum_t grp_sum;

  logic     s2_valid_r;
  logic     s2_last_r;
  grp_sum_t s2_sum_r;

  acc_t     acc_r;
  acc_t     acc_sum;
  acc_t     acc_nxt;

  logic     out_valid_r;
  acc_t     out_sum_r;

  assign cfg_ready = 1'b1;
  assign adv       = !(out_valid_r && out_stall);
  assign in_stall  = !adv;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      sat_r <= 1'b0;
    end else if (cfg_valid && cfg_ready) begin
      sat_r <= cfg_saturate_pairs;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
    end else if (adv) begin
      s1_valid_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      s1_last_r   <= in_last;
      s1_src_r[0] <= in_src0;
      s1_src_r[1] <= in_src1;
      s1_src_r[2] <= in_src2;
      s1_src_r[3] <= in_src3;
      s1_wt_r[0]  <= in_wt0;
      s1_wt_r[1]  <= in_wt1;
      s1_wt_r[2]  <= in_wt2;
      s1_wt_r[3]  <= in_wt3;
    end
  end

  u8s8dp_group u_group (
    .src      (s1_src_r),
    .wt       (s1_wt_r),
    .saturate (sat_r),
    .grp_sum  (grp_sum)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s2_valid_r <= 1'b0;
    end else if (adv) begin
      s2_valid_r <= s1_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      s2_last_r <= s1_last_r;
      s2_sum_r  <= grp_sum;
    end
  end

  assign acc_sum = acc_r + acc_t'(s2_sum_r);
  assign acc_nxt = s2_last_r ? '0 : acc_sum;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      acc_r       <= '0;
      out_valid_r <= 1'b0;
    end else if (adv) begin
      out_valid_r <= s2_valid_r && s2_last_r;
      if (s2_valid_r) begin
        acc_r <= acc_nxt;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      out_sum_r <= acc_sum;
    end
  end

  assign out_valid   = out_valid_r;
  assign out_dot_sum = $signed(out_sum_r);

  a_stall_back: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && out_stall) |-> in_stall)
    else $error("Input not stalled while a result is held.");

  a_acc_clear: assert property (@(posedge clk) disable iff (!rst_n)
    (adv && s2_valid_r && s2_last_r) |=> (acc_r == '0))
    else $error("Accumulator not cleared after the last group.");

  a_emit_src: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid_r) |-> $past(s2_valid_r && s2_last_r))
    else $error("Result presented without a last group.");

  a_sat_range: assert property (@(posedge clk) disable iff (!rst_n)
    (adv && s1_valid_r && sat_r) |=> (s2_sum_r >= -grp_sum_t'(65536) &&
                                      s2_sum_r <= grp_sum_t'(65534)))
    else $error("Saturated group sum out of range.");

endmodule

// ===== sim/u8_s8_dot_product_accumulator_test.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// u8_s8_dot_product_accumulator_test
// Streams groups of four unsigned source bytes and signed weights into the
// dot-product accumulator in exact and pair-saturating modes. Directed
// groups hit the field extremes and the int16 clamp edges, and random dot
// products of random length and tail padding follow. Each emitted sum is
// compared with a running prediction kept by the testbench.
// ----------------------------------------------------------------------------
module u8_s8_dot_product_accumulator_test;
  import u8s8dp_pkg::*;

  localparam int CYCLE_LIMIT  = 400000;
  localparam int PHASE_ITEMS  = 150;
  localparam int NUM_PHASES   = 6;
  localparam int PAIR_MAX     = 2 ** (SAT_W - 1) - 1;
  localparam int PAIR_MIN     = -(2 ** (SAT_W - 1));
  localparam logic MODE_EXACT = 1'b0;
  localparam logic MODE_SAT   = 1'b1;

  typedef struct {
    src_t src[GROUP_SIZE];
    wt_t  wt[GROUP_SIZE];
    logic last;
  } group_t;

  class dot_sum_tracker;
    acc_t running_sum = '0;
    logic saturate = MODE_EXACT;
    acc_t sum_queue[$];
    int   mismatches = 0;

    task report_mismatch(string msg);
      $display("MISMATCH at %0t: %s", $realtime, msg);
      mismatches++;
    endtask

    function void note_group(group_t g);
      int pair;
      for (int p = 0; p < GROUP_SIZE; p += 2) begin
        pair = int'(g.src[p]) * int'(g.wt[p]);
        if (p + 1 < GROUP_SIZE) begin
          pair += int'(g.src[p + 1]) * int'(g.wt[p + 1]);
        end
        if (saturate) begin
          if (pair > PAIR_MAX) begin
            pair = PAIR_MAX;
          end else if (pair < PAIR_MIN) begin
            pair = PAIR_MIN;
          end
        end
        running_sum += acc_t'(pair);
      end
      if (g.last) begin
        sum_queue.push_back(running_sum);
        running_sum = '0;
      end
    endfunction

    task check_sum(logic signed [ACC_W-1:0] got);
      acc_t want;
      if (sum_queue.size() == 0) begin
        report_mismatch($sformatf("dot_sum %0d arrived with no sum pending", got));
      end else begin
        want = sum_queue.pop_front();
        if (got !== want) begin
          report_mismatch($sformatf("dot_sum %0d, predicted %0d", got, $signed(want)));
        end
      end
    endtask
  endclass

  logic               clk = 1'b0;
  logic               rst_n = 1'b0;
  logic               cfg_valid = 1'b0;
  logic               cfg_ready;
  logic               cfg_saturate_pairs = MODE_EXACT;
  logic               in_valid = 1'b0;
  logic               in_stall;
  logic        [7:0]  in_src0 = '0;
  logic        [7:0]  in_src1 = '0;
  logic        [7:0]  in_src2 = '0;
  logic        [7:0]  in_src3 = '0;
  logic signed [7:0]  in_wt0 = '0;
  logic signed [7:0]  in_wt1 = '0;
  logic signed [7:0]  in_wt2 = '0;
  logic signed [7:0]  in_wt3 = '0;
  logic               in_last = 1'b0;
  logic               out_valid;
  logic               out_stall = 1'b0;
  logic signed [31:0] out_dot_sum;

  dot_sum_tracker tracker = new;
  int cycle_count = 0;
  int stall_left = 0;
  bit in_gaps_on = 1'b1;
  bit out_stalls_on = 1'b1;

  u8_s8_dot_product_accumulator dut (
    .clk                (clk),
    .rst_n              (rst_n),
    .cfg_valid          (cfg_valid),
    .cfg_ready          (cfg_ready),
    .cfg_saturate_pairs (cfg_saturate_pairs),
    .in_valid           (in_valid),
    .in_stall           (in_stall),
    .in_src0            (in_src0),
    .in_src1            (in_src1),
    .in_src2            (in_src2),
    .in_src3            (in_src3),
    .in_wt0             (in_wt0),
    .in_wt1             (in_wt1),
    .in_wt2             (in_wt2),
    .in_wt3             (in_wt3),
    .in_last            (in_last),
    .out_valid          (out_valid),
    .out_stall          (out_stall),
    .out_dot_sum        (out_dot_sum)
  );

  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("Test completed with failures");
      $finish;
    end
  end

  always @(posedge clk) begin
    if (rst_n && out_valid && !out_stall) begin
      tracker.check_sum(out_dot_sum);
    end
    if (stall_left > 0) begin
      stall_left <= stall_left - 1;
      out_stall <= 1'b1;
    end else if (out_stalls_on && $urandom_range(0, 9) == 0) begin
      stall_left <= $urandom_range(0, 12);
      out_stall <= 1'b1;
    end else begin
      out_stall <= 1'b0;
    end
  end

  function automatic group_t make_pairs(int s0, int w0, int s1, int w1,
                                        int s2, int w2, int s3, int w3, logic last);
    group_t g;
    g.src[0] = src_t'(s0);
    g.src[1] = src_t'(s1);
    g.src[2] = src_t'(s2);
    g.src[3] = src_t'(s3);
    g.wt[0] = wt_t'(w0);
    g.wt[1] = wt_t'(w1);
    g.wt[2] = wt_t'(w2);
    g.wt[3] = wt_t'(w3);
    g.last = last;
    return g;
  endfunction

  function automatic group_t make_random(int live, logic last);
    group_t g;
    for (int i = 0; i < GROUP_SIZE; i++) begin
      g.src[i] = '0;
      g.wt[i] = '0;
      if (i < live) begin
        case ($urandom_range(0, 5))
          0: g.src[i] = 8'd0;
          1: g.src[i] = 8'd255;
          default: g.src[i] = src_t'($urandom);
        endcase
        case ($urandom_range(0, 6))
          0: g.wt[i] = -8'sd128;
          1: g.wt[i] = 8'sd127;
          2: g.wt[i] = 8'sd0;
          default: g.wt[i] = wt_t'($urandom);
        endcase
      end
    end
    g.last = last;
    return g;
  endfunction

  task automatic send_group(group_t g);
    if (in_gaps_on && $urandom_range(0, 4) == 0) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 13)) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_src0 <= g.src[0];
    in_src1 <= g.src[1];
    in_src2 <= g.src[2];
    in_src3 <= g.src[3];
    in_wt0 <= g.wt[0];
    in_wt1 <= g.wt[1];
    in_wt2 <= g.wt[2];
    in_wt3 <= g.wt[3];
    in_last <= g.last;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    tracker.note_group(g);
  endtask

  task automatic write_mode(logic sat);
    cfg_valid <= 1'b1;
    cfg_saturate_pairs <= sat;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    cfg_valid <= 1'b0;
    tracker.saturate = sat;
  endtask

  task automatic drain();
    in_valid <= 1'b0;
    while (tracker.sum_queue.size() != 0) @(posedge clk);
    repeat (6) @(posedge clk);
  endtask

  task automatic run_directed();
    send_group(make_pairs(0, 0, 0, 0, 0, 0, 0, 0, 1'b1));
    send_group(make_pairs(255, -128, 255, -128, 255, -128, 255, -128, 1'b1));
    send_group(make_pairs(255, 127, 255, 127, 255, 127, 255, 127, 1'b1));
    send_group(make_pairs(255, 127, 255, -128, 0, -128, 128, 1, 1'b1));
    send_group(make_pairs(1, 1, 128, -1, 1, -1, 128, 1, 1'b1));
    // Pair sums just inside and just outside the int16 range.
    send_group(make_pairs(255, 127, 191, 2, 254, 127, 255, 2, 1'b1));
    send_group(make_pairs(255, -128, 1, -128, 255, -128, 129, -1, 1'b1));
    // A dot product over three groups whose final group is zero padded.
    send_group(make_pairs(255, 127, 255, 127, 255, 127, 255, 127, 1'b0));
    send_group(make_pairs(255, -128, 255, -128, 255, -128, 255, -128, 1'b0));
    send_group(make_pairs(255, -128, 0, 0, 0, 0, 0, 0, 1'b1));
    send_group(make_pairs(170, 85, 85, -86, 170, 85, 85, -86, 1'b1));
  endtask

  initial begin
    int items;
    int len;
    int live;
    repeat (9) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    write_mode(MODE_EXACT);
    run_directed();
    drain();
    write_mode(MODE_SAT);
    run_directed();
    drain();

    for (int phase = 0; phase < NUM_PHASES; phase++) begin
      write_mode(phase % 2 == 0 ? MODE_SAT : MODE_EXACT);
      items = 0;
      while (items < PHASE_ITEMS) begin
        if (phase == NUM_PHASES - 1) begin
          in_gaps_on = 1'b0;
          out_stalls_on = 1'b0;
        end else begin
          in_gaps_on = ($urandom_range(0, 3) != 0);
          out_stalls_on = ($urandom_range(0, 3) != 0);
        end
        len = ($urandom_range(0, 7) == 0) ? $urandom_range(7, 14) : $urandom_range(1, 6);
        for (int k = 0; k < len; k++) begin
          live = (k == len - 1 && $urandom_range(0, 2) == 0) ?
                 $urandom_range(0, GROUP_SIZE - 1) : GROUP_SIZE;
          send_group(make_random(live, k == len - 1));
          items++;
        end
      end
      drain();
    end

    if (tracker.mismatches == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

endmodule
